// ----- rtl/atf_pkg.sv -----
package atf_pkg;

  localparam int MULTIPLE_MAX = 16;
  localparam int SECTOR_BYTES = 512;
  localparam int NUM_DRIVES   = 4;
  localparam int SLOTS        = 4;
  localparam int WORDS        = SECTOR_BYTES / 2;
  localparam int BUF_DEPTH    = SLOTS * WORDS;
  localparam int POS_W        = $clog2(WORDS) + 1;

  // Operation codes of a request.
  localparam logic [2:0] OP_REG_WRITE  = 3'd0;
  localparam logic [2:0] OP_REG_READ   = 3'd1;
  localparam logic [2:0] OP_DATA_WRITE = 3'd2;
  localparam logic [2:0] OP_DATA_READ  = 3'd3;
  localparam logic [2:0] OP_MEDIA_FILL = 3'd4;
  localparam logic [2:0] OP_MEDIA_FETCH = 3'd5;
  localparam logic [2:0] OP_MEDIA_DONE = 3'd6;

  // Register addresses.
  localparam logic [3:0] A_BANK0    = 4'd0;
  localparam logic [3:0] A_BANK1    = 4'd1;
  localparam logic [3:0] A_FEATURES = 4'd2;
  localparam logic [3:0] A_SECCNT   = 4'd3;
  localparam logic [3:0] A_SECNUM   = 4'd4;
  localparam logic [3:0] A_CYL_LO   = 4'd5;
  localparam logic [3:0] A_CYL_HI   = 4'd6;
  localparam logic [3:0] A_DRVHEAD  = 4'd7;
  localparam logic [3:0] A_COMMAND  = 4'd8;
  localparam logic [3:0] A_DEVCTL   = 4'd9;
  localparam logic [3:0] A_ALTSTAT  = 4'd10;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DRIVE_TYPES = 2'd0;
  localparam logic [1:0] CFG_INIT_HEADS  = 2'd1;
  localparam logic [1:0] CFG_INIT_SECTORS = 2'd2;

  // Drive types.
  localparam logic [1:0] DT_NONE    = 2'd0;
  localparam logic [1:0] DT_DISK    = 2'd1;
  localparam logic [1:0] DT_OPTICAL = 2'd2;

  // Storage requests.
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_FILL  = 2'd1;
  localparam logic [1:0] REQ_STORE = 2'd2;

  // Commands.
  localparam logic [7:0] CMD_RESET      = 8'h08;
  localparam logic [7:0] CMD_RECAL_FIRST = 8'h10;
  localparam logic [7:0] CMD_RECAL_LAST = 8'h1f;
  localparam logic [7:0] CMD_READ       = 8'h20;
  localparam logic [7:0] CMD_READ_NR    = 8'h21;
  localparam logic [7:0] CMD_WRITE      = 8'h30;
  localparam logic [7:0] CMD_WRITE_NR   = 8'h31;
  localparam logic [7:0] CMD_DIAG       = 8'h90;
  localparam logic [7:0] CMD_SET_PARAMS = 8'h91;
  localparam logic [7:0] CMD_READ_MULT  = 8'hc4;
  localparam logic [7:0] CMD_WRITE_MULT = 8'hc5;
  localparam logic [7:0] CMD_SET_MULT   = 8'hc6;
  localparam logic [7:0] CMD_FLUSH      = 8'he7;

  // Status and control bits.
  localparam logic [7:0] ST_BSY  = 8'h80;
  localparam logic [7:0] ST_DRDY = 8'h40;
  localparam logic [7:0] ST_DSC  = 8'h10;
  localparam logic [7:0] ST_DRQ  = 8'h08;
  localparam logic [7:0] ST_ERR  = 8'h01;
  localparam int CT_NIEN_BIT = 1;
  localparam int CT_SRST_BIT = 2;
  localparam int LBA_BIT     = 2;

  localparam logic [15:0] OPTICAL_CYL = 16'heb14;
  localparam logic [7:0]  NO_DRIVE    = 8'hff;

  typedef struct packed {
    logic [7:0]       sc;
    logic [7:0]       sn;
    logic [15:0]      cyl;
    logic [3:0]       hd;
    logic [3:0]       ldb;
    logic [7:0]       st;
    logic [7:0]       er;
    logic [7:0]       feat;
    logic [7:0]       ctl;
    logic [7:0]       cmd;
    logic [4:0]       gh;
    logic [7:0]       gs;
    logic [7:0]       mm;
    logic [7:0]       mc;
    logic [7:0]       mt;
    logic [POS_W-1:0] pos;
    logic             dir;
  } drv_t;

  function automatic logic [1:0] dtype(input logic [7:0] types, input logic [2:0] idx);
    logic [1:0] t;
    t = 2'(types >> {idx[1:0], 1'b0});
    if (int'(idx) >= NUM_DRIVES || int'(idx) >= SLOTS || t == 2'd3) t = DT_NONE;
    return t;
  endfunction

  function automatic drv_t drv_reset(input drv_t w, input logic [1:0] t);
    drv_t r;
    r    = w;
    r.hd = '0;
    r.sc = 8'd1;
    r.sn = 8'd1;
    if (t == DT_OPTICAL) begin
      r.ldb = w.ldb | 4'd1;
      r.cyl = OPTICAL_CYL;
      r.st  = '0;
    end else begin
      r.cyl = '0;
      r.st  = ST_DRDY;
    end
    return r;
  endfunction

  function automatic drv_t power_init(input logic [1:0] t, input logic [4:0] heads,
                                      input logic [7:0] sectors);
    drv_t r;
    r    = '0;
    r.sc = 8'd1;
    r.sn = 8'd1;
    r.gh = heads;
    r.gs = sectors;
    r.mm = 8'(MULTIPLE_MAX);
    if (t == DT_DISK) begin
      r.st = ST_DRDY | ST_DSC;
      r.er = 8'd1;
    end else if (t == DT_OPTICAL) begin
      r = drv_reset(r, t);
    end else begin
      r.st = ST_ERR;
    end
    return r;
  endfunction

  function automatic drv_t next_sector(input drv_t w);
    drv_t       r;
    logic [4:0] h;
    r    = w;
    r.sn = w.sn + 8'd1;
    h    = {1'b0, w.hd} + 5'd1;
    if (!w.ldb[LBA_BIT]) begin
      if (r.sn > w.gs) begin
        r.sn = 8'd1;
        if (h < w.gh && !h[4]) begin
          r.hd = h[3:0];
        end else begin
          r.hd  = '0;
          r.cyl = w.cyl + 16'd1;
        end
      end
    end else if (r.sn == 8'd0) begin
      r.cyl = w.cyl + 16'd1;
      if (r.cyl == 16'd0) r.hd = w.hd + 4'd1;
    end
    return r;
  endfunction

  function automatic drv_t data_ready(input drv_t w, input logic out_dir);
    drv_t r;
    r     = w;
    r.dir = out_dir;
    r.pos = '0;
    r.st  = ST_DRDY | ST_DSC | ST_DRQ;
    r.er  = '0;
    return r;
  endfunction

  function automatic logic block_edge(input drv_t w);
    return (w.mc & (w.mt - 8'd1)) == 8'd0;
  endfunction

endpackage

// ----- rtl/atf_ram.sv -----
module atf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ata_task_file_controller.sv -----
// Channel        | Ports                                          | Transfer
// ---------------+------------------------------------------------+---------------------------
// request in     | start, busy, in_operation/reg_addr/...         | taken when start & !busy
// result out     | out_valid, out_read_data, out_irq, out_storage_* | one cycle per strobe
// configuration  | cfg_we, cfg_index, cfg_wdata                   | taken when cfg_we is high
//
// A request passes an accept and an execute state: the buffer RAM is addressed
// in the cycle of acceptance and its registered data is consumed in the
// execute cycle. A storage-issuing request goes on through S_LBA1 and S_LBA2,
// because the CHS sector number goes through two registered multiplies.
// Reset is synchronous and puts every drive in its power-on state.
// The receiver cannot stall; each result is shown for exactly one cycle.
module ata_task_file_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [3:0]  in_reg_addr,
  input  logic [15:0] in_write_data,
  input  logic        in_media_ok,
  output logic        out_valid,
  output logic [15:0] out_read_data,
  output logic        out_irq,
  output logic [1:0]  out_storage_request,
  output logic [1:0]  out_storage_drive,
  output logic [27:0] out_storage_lba,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import atf_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int WW = $clog2(WORDS);

  // Sequencer: accept, execute, then, for a storage transfer, two steps of sector address math.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LBA1 = 2'd2;
  localparam logic [1:0] S_LBA2 = 2'd3;

  logic [1:0]  state_r, state_nxt;

  // Configuration registers.
  logic [7:0]  types_r, types_nxt;
  logic [4:0]  heads_r, heads_nxt;
  logic [7:0]  sectors_r, sectors_nxt;
  logic        cfg_hit;

  // Host-visible shared state.
  logic [7:0]  bank_r [2];
  logic [7:0]  bank_nxt [2];
  logic        sel_r [2];
  logic        sel_nxt [2];
  logic        irq_r, irq_nxt;
  logic [1:0]  await_r, await_nxt;
  logic [1:0]  pend_r, pend_nxt;

  // Per-drive task file.
  drv_t        drv_r [SLOTS];
  drv_t        drv_nxt [SLOTS];

  // Latched request.
  logic [2:0]  op_r;
  logic [3:0]  addr_r;
  logic [15:0] wd_r;
  logic        ok_r;

  // Issue bookkeeping for the address math.
  logic        issue;
  logic [1:0]  iss_kind, iss_d;
  logic [1:0]  lba_kind_r;
  logic [1:0]  lba_drv_r;
  logic [20:0] prod_r;

  // Buffer RAM.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  // Result formed in the execute cycle.
  logic [15:0] rd_val;

  // Selected channel from the bank register, and drive from that channel's select bit.
  logic        chan_ok;
  logic        chan;
  logic [1:0]  cur_d;
  logic        cur_ok;

  assign chan_ok = (bank_r[1][6:1] == 6'd0);
  assign chan    = bank_r[1][0];
  assign cur_d   = {chan, sel_r[chan]};
  assign cur_ok  = chan_ok && (dtype(types_r, {1'b0, cur_d}) != DT_NONE);
  assign busy    = (state_r != S_IDLE);

  // The read address is set up while the request is being accepted, so the
  // word is ready in the execute cycle. Nothing changes in between.
  always_comb begin
    if (in_operation == OP_MEDIA_FETCH) begin
      ram_raddr = {pend_r, drv_r[pend_r].pos[WW-1:0]};
    end else begin
      ram_raddr = {cur_d, drv_r[cur_d].pos[WW-1:0]};
    end
  end

  atf_ram #(.WIDTH(16), .DEPTH(BUF_DEPTH)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Execute cycle: the whole task-file update for one request.
  always_comb begin
    drv_t       w;
    logic [1:0] d;
    logic [1:0] d0;
    logic       intr;
    logic [1:0] intr_d;
    logic [7:0] v;
    logic [7:0] mods;
    logic [7:0] cm;
    logic [1:0] t;

    drv_nxt   = drv_r;
    bank_nxt  = bank_r;
    sel_nxt   = sel_r;
    irq_nxt   = irq_r;
    await_nxt = await_r;
    pend_nxt  = pend_r;
    ram_we    = 1'b0;
    ram_waddr = {cur_d, drv_r[cur_d].pos[WW-1:0]};
    ram_wdata = wd_r;
    rd_val    = '0;
    issue     = 1'b0;
    iss_kind  = REQ_NONE;
    iss_d     = cur_d;
    intr      = 1'b0;
    intr_d    = cur_d;
    v         = wd_r[7:0];
    d         = cur_d;
    d0        = {chan, 1'b0};
    w         = drv_r[cur_d];
    mods      = '0;
    cm        = drv_r[cur_d].cmd;
    t         = dtype(types_r, {1'b0, cur_d});

    if (state_r == S_EXEC) begin
      case (op_r)
        OP_REG_WRITE: begin
          if (addr_r == A_BANK0 || addr_r == A_BANK1) begin
            if (!v[7]) bank_nxt[addr_r[0]] = v;
          end else if (addr_r >= A_FEATURES && addr_r <= A_CYL_HI) begin
            if (cur_ok) begin
              case (addr_r)
                A_FEATURES: drv_nxt[d].feat = v;
                A_SECCNT:   drv_nxt[d].sc = v;
                A_SECNUM:   drv_nxt[d].sn = v;
                A_CYL_LO:   drv_nxt[d].cyl[7:0] = v;
                default:    drv_nxt[d].cyl[15:8] = v;
              endcase
            end
          end else if (addr_r == A_DRVHEAD) begin
            if (chan_ok) begin
              sel_nxt[chan] = v[4];
              drv_nxt[{chan, v[4]}].ldb = v[7:4];
              drv_nxt[{chan, v[4]}].hd  = v[3:0];
            end
          end else if (addr_r == A_COMMAND) begin
            if (await_r != REQ_NONE) begin
              // A pending transfer locks out new commands.
            end else if (v == CMD_DIAG) begin
              if (chan_ok) begin
                for (int i = 0; i < 2; i++) begin
                  drv_nxt[{chan, i[0]}] = drv_reset(drv_r[{chan, i[0]}],
                                                    dtype(types_r, {1'b0, chan, i[0]}));
                  drv_nxt[{chan, i[0]}].er =
                    (dtype(types_r, {1'b0, chan, i[0]}) != DT_NONE) ? 8'd1 : 8'd0;
                end
                if (dtype(types_r, {1'b0, chan, 1'b1}) == DT_NONE) begin
                  drv_nxt[d0].er = drv_nxt[d0].er | 8'h80;
                end
              end
            end else if (cur_ok) begin
              w     = drv_r[d];
              w.cmd = v;
              case (v) inside
                CMD_RESET: begin
                  w    = drv_reset(w, t);
                  w.er = 8'd1;
                  if (!sel_r[chan] && dtype(types_r, {1'b0, d} + 3'd1) == DT_NONE) begin
                    w.er = w.er | 8'h80;
                  end
                  intr = 1'b1;
                end
                [CMD_RECAL_FIRST:CMD_RECAL_LAST]: begin
                  if (t != DT_DISK) begin
                    w.st = ST_DRDY | ST_ERR; w.er = 8'h04;
                  end else begin
                    w.hd  = '0;
                    w.sc  = '0;
                    w.cyl = '0;
                    w.sn  = w.ldb[LBA_BIT] ? 8'd0 : 8'd1;
                    w.st  = ST_DRDY | ST_DSC;
                    w.er  = '0;
                  end
                  intr = 1'b1;
                end
                CMD_READ, CMD_READ_NR, CMD_WRITE, CMD_WRITE_NR, CMD_READ_MULT,
                CMD_WRITE_MULT: begin
                  if (t != DT_DISK || ((v[7:4] == 4'hc) && MULTIPLE_MAX <= 0)) begin
                    w.st = ST_DRDY | ST_ERR; w.er = 8'h04;
                    intr = 1'b1;
                  end else begin
                    w.mc = '0;
                    w.mt = (v[7:4] == 4'hc) ? w.mm : 8'd1;
                    if (v == CMD_READ || v == CMD_READ_NR || v == CMD_READ_MULT) begin
                      w.pos     = '0;
                      w.st      = ST_BSY | ST_DRDY | ST_DSC;
                      issue     = 1'b1;
                      iss_kind  = REQ_FILL;
                      await_nxt = REQ_FILL;
                      pend_nxt  = d;
                    end else begin
                      intr = block_edge(w);
                      w    = data_ready(w, 1'b1);
                    end
                  end
                end
                CMD_SET_PARAMS: begin
                  if (t != DT_DISK) begin
                    w.st = ST_DRDY | ST_ERR; w.er = 8'h04;
                  end else begin
                    w.gh = {1'b0, w.hd} + 5'd1;
                    w.gs = w.sc;
                    w.st = (w.st & ~(ST_BSY | ST_DRQ | ST_ERR)) | ST_DRDY;
                  end
                  intr = 1'b1;
                end
                CMD_SET_MULT: begin
                  if (t == DT_DISK && w.sc >= 8'd2 && (w.sc & (w.sc - 8'd1)) == 8'd0 &&
                      int'(w.sc) <= MULTIPLE_MAX) begin
                    w.mm = w.sc;
                  end else begin
                    w.st = ST_DRDY | ST_ERR; w.er = 8'h04;
                  end
                  intr = 1'b1;
                end
                CMD_FLUSH: begin
                  w.st = ST_DRDY;
                  w.er = '0;
                  intr = 1'b1;
                end
                default: begin
                  w.st = ST_DRDY | ST_ERR; w.er = 8'h04;
                  intr = 1'b1;
                end
              endcase
              drv_nxt[d] = w;
            end
          end else if (addr_r == A_DEVCTL) begin
            if (chan_ok) begin
              mods = drv_r[d0].ctl ^ v;
              drv_nxt[d0].ctl = v;
              drv_nxt[{chan, 1'b1}].ctl = v;
              if (mods[CT_SRST_BIT]) begin
                if (await_r != REQ_NONE && pend_r[1] == chan) await_nxt = REQ_NONE;
                for (int i = 0; i < 2; i++) begin
                  if (v[CT_SRST_BIT]) begin
                    drv_nxt[{chan, i[0]}].st = '0;
                    drv_nxt[{chan, i[0]}].er = '0;
                  end else begin
                    drv_nxt[{chan, i[0]}] = drv_reset(drv_nxt[{chan, i[0]}],
                                                      dtype(types_r, {1'b0, chan, i[0]}));
                    if (dtype(types_r, {1'b0, chan, i[0]}) == DT_DISK) begin
                      drv_nxt[{chan, i[0]}].st = ST_DRDY | ST_DSC;
                      drv_nxt[{chan, i[0]}].er = 8'd1;
                    end
                  end
                end
              end
            end
          end
        end

        OP_REG_READ: begin
          if (addr_r == A_BANK0 || addr_r == A_BANK1) begin
            rd_val = {8'd0, bank_r[addr_r[0]] & 8'h81};
            bank_nxt[addr_r[0]] = bank_r[addr_r[0]] & 8'h7f;
          end else if (!cur_ok || addr_r > A_ALTSTAT) begin
            rd_val = {8'd0, NO_DRIVE};
          end else begin
            case (addr_r)
              A_FEATURES: begin
                rd_val = {8'd0, w.er};
                drv_nxt[d].st = w.st & ~ST_ERR;
              end
              A_SECCNT:  rd_val = {8'd0, w.sc};
              A_SECNUM:  rd_val = {8'd0, w.sn};
              A_CYL_LO:  rd_val = {8'd0, w.cyl[7:0]};
              A_CYL_HI:  rd_val = {8'd0, w.cyl[15:8]};
              A_DRVHEAD: rd_val = {8'd0, w.ldb, w.hd};
              A_COMMAND: begin
                rd_val = {8'd0, w.st};
                if (!w.ctl[CT_NIEN_BIT]) irq_nxt = 1'b0;
              end
              default:   rd_val = {8'd0, w.st};
            endcase
          end
        end

        OP_DATA_WRITE: begin
          if (cur_ok && (w.st & ST_DRQ) != 8'd0 && w.dir && !w.pos[POS_W-1]) begin
            ram_we = 1'b1;
            w.pos  = w.pos + 1'b1;
            if (w.pos[POS_W-1]) begin
              w.st = w.st & ~ST_DRQ;
              if (cm == CMD_WRITE || cm == CMD_WRITE_NR || cm == CMD_WRITE_MULT) begin
                w.pos     = '0;
                w.st      = ST_BSY | ST_DRDY | ST_DSC;
                issue     = 1'b1;
                iss_kind  = REQ_STORE;
                await_nxt = REQ_STORE;
                pend_nxt  = d;
              end
            end
            drv_nxt[d] = w;
          end
        end

        OP_DATA_READ: begin
          if (!cur_ok) begin
            rd_val = {8'd0, NO_DRIVE};
          end else if ((w.st & ST_DRQ) != 8'd0 && !w.dir && !w.pos[POS_W-1]) begin
            rd_val = ram_rdata;
            w.pos  = w.pos + 1'b1;
            if (w.pos[POS_W-1]) begin
              w.st = w.st & ~ST_DRQ;
              if (cm == CMD_READ || cm == CMD_READ_NR || cm == CMD_READ_MULT) begin
                w    = next_sector(w);
                w.sc = w.sc - 8'd1;
                if (w.sc != 8'd0) begin
                  w.pos     = '0;
                  w.st      = ST_BSY | ST_DRDY | ST_DSC;
                  issue     = 1'b1;
                  iss_kind  = REQ_FILL;
                  await_nxt = REQ_FILL;
                  pend_nxt  = d;
                end
              end
            end
            drv_nxt[d] = w;
          end
        end

        OP_MEDIA_FILL: begin
          if (await_r == REQ_FILL && !drv_r[pend_r].pos[POS_W-1]) begin
            ram_we    = 1'b1;
            ram_waddr = {pend_r, drv_r[pend_r].pos[WW-1:0]};
            drv_nxt[pend_r].pos = drv_r[pend_r].pos + 1'b1;
          end
        end

        OP_MEDIA_FETCH: begin
          if (await_r == REQ_STORE && !drv_r[pend_r].pos[POS_W-1]) begin
            rd_val = ram_rdata;
            drv_nxt[pend_r].pos = drv_r[pend_r].pos + 1'b1;
          end
        end

        OP_MEDIA_DONE: begin
          if (await_r != REQ_NONE) begin
            await_nxt = REQ_NONE;
            intr_d    = pend_r;
            w         = drv_r[pend_r];
            if (!ok_r) begin
              w.st = ST_DRDY | ST_ERR; w.er = 8'h04;
              intr = 1'b1;
            end else if (await_r == REQ_FILL) begin
              intr = block_edge(w);
              w    = data_ready(w, 1'b0);
              w.mc = w.mc + 8'd1;
            end else begin
              w.st = ST_DRDY | ST_DSC;
              w.mc = w.mc + 8'd1;
              w    = next_sector(w);
              w.sc = w.sc - 8'd1;
              if (w.sc != 8'd0) begin
                intr = block_edge(w);
                w    = data_ready(w, 1'b1);
              end
            end
            drv_nxt[pend_r] = w;
          end
        end

        default: begin
        end
      endcase

      // Interrupt, unless the drive has it masked in device control.
      if (intr && !drv_r[intr_d].ctl[CT_NIEN_BIT]) begin
        bank_nxt[0] = bank_r[1] | 8'h80;
        irq_nxt     = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = issue ? S_LBA1 : S_IDLE;
      S_LBA1:  state_nxt = S_LBA2;
      S_LBA2:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // A configuration write to a defined index updates one register and redoes power-on setup.
  always_comb begin
    types_nxt   = types_r;
    heads_nxt   = heads_r;
    sectors_nxt = sectors_r;
    cfg_hit     = 1'b1;
    case (cfg_index)
      CFG_DRIVE_TYPES:  types_nxt = cfg_wdata;
      CFG_INIT_HEADS:   heads_nxt = cfg_wdata[4:0];
      CFG_INIT_SECTORS: sectors_nxt = cfg_wdata;
      default:          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      types_r   <= 8'd1;
      heads_r   <= 5'd8;
      sectors_r <= 8'd17;
      bank_r    <= '{default: '0};
      sel_r     <= '{default: 1'b0};
      irq_r     <= 1'b0;
      await_r   <= REQ_NONE;
      pend_r    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        drv_r[i] <= power_init(dtype(8'd1, 3'(i)), 5'd8, 8'd17);
      end
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_EXEC && !issue) || state_r == S_LBA2;
      if (cfg_we) begin
        if (cfg_hit) begin
          types_r   <= types_nxt;
          heads_r   <= heads_nxt;
          sectors_r <= sectors_nxt;
          await_r   <= REQ_NONE;
          pend_r    <= '0;
          for (int i = 0; i < SLOTS; i++) begin
            drv_r[i] <= power_init(dtype(types_nxt, 3'(i)), heads_nxt, sectors_nxt);
          end
        end
      end else begin
        bank_r  <= bank_nxt;
        sel_r   <= sel_nxt;
        irq_r   <= irq_nxt;
        await_r <= await_nxt;
        pend_r  <= pend_nxt;
        drv_r   <= drv_nxt;
      end
    end
  end

  // Request latch, address math and result registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op_r   <= in_operation;
      addr_r <= in_reg_addr;
      wd_r   <= in_write_data;
      ok_r   <= in_media_ok;
    end
    if (state_r == S_EXEC) begin
      out_read_data <= rd_val;
      out_irq       <= irq_nxt;
      lba_kind_r    <= iss_kind;
      lba_drv_r     <= iss_d;
      if (!issue) begin
        out_storage_request <= REQ_NONE;
        out_storage_drive   <= '0;
        out_storage_lba     <= '0;
      end
    end
    if (state_r == S_LBA1) begin
      prod_r <= {5'd0, drv_r[lba_drv_r].cyl} * {16'd0, drv_r[lba_drv_r].gh} +
                {17'd0, drv_r[lba_drv_r].hd};
    end
    if (state_r == S_LBA2) begin
      out_storage_request <= lba_kind_r;
      out_storage_drive   <= lba_drv_r;
      if (drv_r[lba_drv_r].ldb[LBA_BIT]) begin
        out_storage_lba <= {drv_r[lba_drv_r].hd, drv_r[lba_drv_r].cyl,
                            drv_r[lba_drv_r].sn};
      end else begin
        out_storage_lba <= 28'({9'd0, prod_r} * {22'd0, drv_r[lba_drv_r].gs} +
                               {22'd0, drv_r[lba_drv_r].sn} - 30'd1);
      end
    end
  end

endmodule

// ----- rtl/atf_checker.sv -----
module atf_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_storage_request,
  input logic [1:0]  out_storage_drive,
  input logic [27:0] out_storage_lba
);

  // An accepted request keeps the block busy for at least its execute cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // No two results come in consecutive cycles.
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // A result without a storage request carries no drive or sector.
  a_quiet_storage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_storage_request == 2'd0 |->
      out_storage_drive == 2'd0 && out_storage_lba == 28'd0)
    else $error("storage fields set without a request");

  a_req_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_storage_request != 2'd3)
    else $error("undefined storage request code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind ata_task_file_controller atf_assertions u_atf_assertions (.*);

// ----- test/atf_checker.sv -----
// Task-file predictor and result checker. It watches the request channel and
// the configuration port, keeps its own copy of every drive's task registers,
// sector buffers and pending storage transfer, and compares each result
// strobe against the oldest predicted result.
module atf_checker
  import atf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [3:0]  in_reg_addr,
  input  logic [15:0] in_write_data,
  input  logic        in_media_ok,
  input  logic        out_valid,
  input  logic [15:0] out_read_data,
  input  logic        out_irq,
  input  logic [1:0]  out_storage_request,
  input  logic [1:0]  out_storage_drive,
  input  logic [27:0] out_storage_lba,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [7:0] ERR_ABORTED  = 8'h04;
  localparam logic [7:0] ERR_DIAG_OK  = 8'h01;
  localparam logic [7:0] ERR_NO_SLAVE = 8'h80;
  localparam logic [7:0] BANK_IRQ     = 8'h80;
  localparam logic [7:0] BANK_MASK    = 8'h7f;
  localparam logic [7:0] BANK_VISIBLE = 8'h81;

  typedef struct packed {
    logic [15:0] rd;
    logic        irq;
    logic [1:0]  req;
    logic [1:0]  drv;
    logic [27:0] lba;
  } ata_result_t;

  ata_result_t pending_results[$];

  logic [7:0]  drive_types;
  logic [4:0]  init_heads;
  logic [7:0]  init_sectors;
  logic [7:0]  bank[2];
  logic        sel[2];
  logic [7:0]  sc[SLOTS], sn[SLOTS], st[SLOTS], er[SLOTS], feat[SLOTS], ctl[SLOTS];
  logic [7:0]  cmdr[SLOTS], gs[SLOTS], mm[SLOTS], mc[SLOTS], mt[SLOTS];
  logic [15:0] cyl[SLOTS];
  logic [3:0]  hd[SLOTS], ldb[SLOTS];
  logic [4:0]  gh[SLOTS];
  int          pos[SLOTS];
  logic        dir_out[SLOTS];
  logic [15:0] sector_words[BUF_DEPTH];
  logic [1:0]  xfer_kind;
  int          xfer_drive;
  logic        irq_line;
  ata_result_t res;

  initial mismatches = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %0h, predicted %0h", what, got, want);
    mismatches++;
  endtask

  function automatic logic [1:0] kind_of(input int d);
    logic [1:0] t;
    if (d >= NUM_DRIVES || d >= SLOTS) return DT_NONE;
    t = drive_types[2*d +: 2];
    if (t == 2'd3) t = DT_NONE;
    return t;
  endfunction

  function automatic int channel();
    int c;
    c = int'(bank[1] & BANK_MASK);
    return (c < 2) ? c : -1;
  endfunction

  function automatic int current();
    int c, d;
    c = channel();
    if (c < 0) return -1;
    d = 2 * c + int'(sel[c]);
    return (kind_of(d) != DT_NONE) ? d : -1;
  endfunction

  function automatic void raise_irq(input int d);
    if (!ctl[d][CT_NIEN_BIT]) begin
      bank[0] = bank[1] | BANK_IRQ;
      irq_line = 1'b1;
    end
  endfunction

  function automatic void abort_cmd(input int d);
    st[d] = ST_DRDY | ST_ERR;
    er[d] = ERR_ABORTED;
    raise_irq(d);
  endfunction

  function automatic void drive_reset(input int d);
    hd[d] = '0;
    sc[d] = 8'd1;
    sn[d] = 8'd1;
    if (kind_of(d) == DT_OPTICAL) begin
      ldb[d] = ldb[d] | 4'd1;
      cyl[d] = OPTICAL_CYL;
      st[d]  = '0;
    end else begin
      cyl[d] = '0;
      st[d]  = ST_DRDY;
    end
  endfunction

  function automatic void power_up(input int d);
    logic [1:0] t;
    t = kind_of(d);
    sc[d] = 8'd1; sn[d] = 8'd1; cyl[d] = '0; hd[d] = '0; ldb[d] = '0;
    feat[d] = '0; ctl[d] = '0; cmdr[d] = '0;
    gh[d] = init_heads; gs[d] = init_sectors; mm[d] = 8'(MULTIPLE_MAX);
    mc[d] = '0; mt[d] = '0; pos[d] = 0; dir_out[d] = 1'b0;
    if (t == DT_DISK) begin
      st[d] = ST_DRDY | ST_DSC;
      er[d] = 8'd1;
    end else if (t == DT_OPTICAL) begin
      drive_reset(d);
      er[d] = '0;
    end else begin
      st[d] = ST_ERR;
      er[d] = '0;
    end
  endfunction

  function automatic void power_all();
    for (int d = 0; d < SLOTS; d++) power_up(d);
    xfer_kind = REQ_NONE;
    xfer_drive = 0;
  endfunction

  function automatic logic [27:0] linear_sector(input int d);
    logic [31:0] r;
    if (!ldb[d][LBA_BIT]) begin
      r = 32'(cyl[d]) * 32'(gh[d]) + 32'(hd[d]);
      r = r * 32'(gs[d]) + 32'(sn[d]) - 32'd1;
      return r[27:0];
    end
    return {hd[d], cyl[d], sn[d]};
  endfunction

  function automatic void advance_sector(input int d);
    int h;
    sn[d] = sn[d] + 8'd1;
    if (!ldb[d][LBA_BIT]) begin
      if (sn[d] <= gs[d]) return;
      sn[d] = 8'd1;
      h = int'(hd[d]) + 1;
      if (h < int'(gh[d]) && h < 16) begin
        hd[d] = 4'(h);
        return;
      end
      hd[d] = '0;
      cyl[d] = cyl[d] + 16'd1;
    end else begin
      if (sn[d] != 8'd0) return;
      cyl[d] = cyl[d] + 16'd1;
      if (cyl[d] != 16'd0) return;
      hd[d] = hd[d] + 4'd1;
    end
  endfunction

  function automatic void start_transfer(input int d, input logic [1:0] kind);
    res.req = kind;
    res.drv = 2'(d);
    res.lba = linear_sector(d);
    xfer_kind = kind;
    xfer_drive = d;
    pos[d] = 0;
    st[d] = ST_BSY | ST_DRDY | ST_DSC;
  endfunction

  function automatic void drq_ready(input int d, input logic out_dir);
    logic [7:0] m;
    dir_out[d] = out_dir;
    pos[d] = 0;
    st[d] = ST_DRDY | ST_DSC | ST_DRQ;
    er[d] = '0;
    m = mt[d] - 8'd1;
    if ((mc[d] & m) == 8'd0) raise_irq(d);
  endfunction

  function automatic logic is_read_cmd(input logic [7:0] c);
    return c == CMD_READ || c == CMD_READ_NR || c == CMD_READ_MULT;
  endfunction

  function automatic logic is_write_cmd(input logic [7:0] c);
    return c == CMD_WRITE || c == CMD_WRITE_NR || c == CMD_WRITE_MULT;
  endfunction

  function automatic void run_command(input logic [7:0] dat);
    int c, d;
    logic [7:0] op, n;
    if (xfer_kind != REQ_NONE) return;
    if (dat == CMD_DIAG) begin
      c = channel();
      if (c < 0) return;
      for (int i = 0; i < 2; i++) begin
        d = 2 * c + i;
        drive_reset(d);
        er[d] = (kind_of(d) != DT_NONE) ? ERR_DIAG_OK : 8'd0;
        if (i == 0 && kind_of(d + 1) == DT_NONE) er[d] = er[d] | ERR_NO_SLAVE;
      end
      return;
    end
    d = current();
    if (d < 0) return;
    c = channel();
    cmdr[d] = dat;
    op = (dat >= CMD_RECAL_FIRST && dat <= CMD_RECAL_LAST) ? CMD_RECAL_FIRST : dat;
    case (op)
      CMD_RESET: begin
        drive_reset(d);
        er[d] = ERR_DIAG_OK;
        if (!sel[c] && kind_of(d + 1) == DT_NONE) er[d] = er[d] | ERR_NO_SLAVE;
        raise_irq(d);
      end
      CMD_RECAL_FIRST: begin
        if (kind_of(d) != DT_DISK) abort_cmd(d);
        else begin
          hd[d] = '0; sc[d] = '0; cyl[d] = '0;
          sn[d] = ldb[d][LBA_BIT] ? 8'd0 : 8'd1;
          st[d] = ST_DRDY | ST_DSC;
          er[d] = '0;
          raise_irq(d);
        end
      end
      CMD_READ, CMD_READ_NR, CMD_WRITE, CMD_WRITE_NR, CMD_READ_MULT, CMD_WRITE_MULT: begin
        if (kind_of(d) != DT_DISK) abort_cmd(d);
        else begin
          mc[d] = '0;
          mt[d] = (op == CMD_READ_MULT || op == CMD_WRITE_MULT) ? mm[d] : 8'd1;
          if (is_read_cmd(op)) start_transfer(d, REQ_FILL);
          else drq_ready(d, 1'b1);
        end
      end
      CMD_SET_PARAMS: begin
        if (kind_of(d) != DT_DISK) abort_cmd(d);
        else begin
          gh[d] = 5'(hd[d]) + 5'd1;
          gs[d] = sc[d];
          st[d] = (st[d] & ~(ST_BSY | ST_DRQ | ST_ERR)) | ST_DRDY;
          raise_irq(d);
        end
      end
      CMD_SET_MULT: begin
        n = sc[d];
        if (kind_of(d) == DT_DISK && n >= 8'd2 && (n & (n - 8'd1)) == 8'd0 &&
            int'(n) <= MULTIPLE_MAX) begin
          mm[d] = n;
          raise_irq(d);
        end else begin
          abort_cmd(d);
        end
      end
      CMD_FLUSH: begin
        st[d] = ST_DRDY;
        er[d] = '0;
        raise_irq(d);
      end
      default: abort_cmd(d);
    endcase
  endfunction

  function automatic void dev_control(input logic [7:0] dat);
    int c, d0, d;
    logic [7:0] changed;
    c = channel();
    if (c < 0) return;
    d0 = 2 * c;
    changed = ctl[d0] ^ dat;
    ctl[d0] = dat;
    ctl[d0 + 1] = dat;
    if (!changed[CT_SRST_BIT]) return;
    if (xfer_kind != REQ_NONE && (xfer_drive >> 1) == c) xfer_kind = REQ_NONE;
    for (int i = 0; i < 2; i++) begin
      d = d0 + i;
      if (dat[CT_SRST_BIT]) begin
        st[d] = '0;
        er[d] = '0;
      end else begin
        drive_reset(d);
        if (kind_of(d) == DT_DISK) begin
          st[d] = ST_DRDY | ST_DSC;
          er[d] = ERR_DIAG_OK;
        end
      end
    end
  endfunction

  function automatic void reg_write(input logic [3:0] a, input logic [7:0] v);
    int di, c, d;
    di = current();
    if (a < A_FEATURES) begin
      if (!v[7]) bank[a[0]] = v;
      return;
    end
    if (a <= A_CYL_HI) begin
      if (di < 0) return;
      case (a)
        A_FEATURES: feat[di] = v;
        A_SECCNT:   sc[di] = v;
        A_SECNUM:   sn[di] = v;
        A_CYL_LO:   cyl[di][7:0] = v;
        default:    cyl[di][15:8] = v;
      endcase
      return;
    end
    if (a == A_DRVHEAD) begin
      c = channel();
      if (c < 0) return;
      sel[c] = v[4];
      d = 2 * c + int'(sel[c]);
      ldb[d] = v[7:4];
      hd[d] = v[3:0];
    end else if (a == A_COMMAND) begin
      run_command(v);
    end else if (a == A_DEVCTL) begin
      dev_control(v);
    end
  endfunction

  function automatic logic [15:0] reg_read(input logic [3:0] a);
    int di;
    logic [7:0] r;
    if (a < A_FEATURES) begin
      r = bank[a[0]];
      bank[a[0]] = r & BANK_MASK;
      return 16'(r & BANK_VISIBLE);
    end
    di = current();
    if (di < 0 || a > A_ALTSTAT) return 16'(NO_DRIVE);
    case (a)
      A_FEATURES: begin
        st[di] = st[di] & ~ST_ERR;
        return 16'(er[di]);
      end
      A_SECCNT:  return 16'(sc[di]);
      A_SECNUM:  return 16'(sn[di]);
      A_CYL_LO:  return 16'(cyl[di][7:0]);
      A_CYL_HI:  return 16'(cyl[di][15:8]);
      A_DRVHEAD: return 16'({ldb[di], hd[di]});
      A_COMMAND: begin
        if (!ctl[di][CT_NIEN_BIT]) irq_line = 1'b0;
        return 16'(st[di]);
      end
      default:   return 16'(st[di]);
    endcase
  endfunction

  function automatic void data_write(input logic [15:0] v);
    int d;
    d = current();
    if (d < 0) return;
    if (!(st[d] & ST_DRQ) || !dir_out[d] || pos[d] >= WORDS) return;
    sector_words[d * WORDS + pos[d]] = v;
    pos[d]++;
    if (pos[d] < WORDS) return;
    st[d] = st[d] & ~ST_DRQ;
    if (is_write_cmd(cmdr[d])) start_transfer(d, REQ_STORE);
  endfunction

  function automatic logic [15:0] data_read();
    int d;
    logic [15:0] r;
    d = current();
    if (d < 0) return 16'(NO_DRIVE);
    if (!(st[d] & ST_DRQ) || dir_out[d] || pos[d] >= WORDS) return '0;
    r = sector_words[d * WORDS + pos[d]];
    pos[d]++;
    if (pos[d] >= WORDS) begin
      st[d] = st[d] & ~ST_DRQ;
      if (is_read_cmd(cmdr[d])) begin
        advance_sector(d);
        sc[d] = sc[d] - 8'd1;
        if (sc[d] != 8'd0) start_transfer(d, REQ_FILL);
      end
    end
    return r;
  endfunction

  function automatic void media_done(input logic ok);
    int d;
    logic [1:0] kind;
    d = xfer_drive;
    kind = xfer_kind;
    if (kind == REQ_NONE) return;
    xfer_kind = REQ_NONE;
    if (!ok) begin
      abort_cmd(d);
      return;
    end
    if (kind == REQ_FILL) begin
      drq_ready(d, 1'b0);
      mc[d] = mc[d] + 8'd1;
      return;
    end
    st[d] = ST_DRDY | ST_DSC;
    mc[d] = mc[d] + 8'd1;
    advance_sector(d);
    sc[d] = sc[d] - 8'd1;
    if (sc[d] != 8'd0) drq_ready(d, 1'b1);
  endfunction

  function automatic void task_file_step(input logic [2:0] op, input logic [3:0] a,
                                         input logic [15:0] wd, input logic ok);
    int d;
    d = xfer_drive;
    res = '0;
    case (op)
      OP_REG_WRITE:  reg_write(a, wd[7:0]);
      OP_REG_READ:   res.rd = reg_read(a);
      OP_DATA_WRITE: data_write(wd);
      OP_DATA_READ:  res.rd = data_read();
      OP_MEDIA_FILL: begin
        if (xfer_kind == REQ_FILL && pos[d] < WORDS) begin
          sector_words[d * WORDS + pos[d]] = wd;
          pos[d]++;
        end
      end
      OP_MEDIA_FETCH: begin
        if (xfer_kind == REQ_STORE && pos[d] < WORDS) begin
          res.rd = sector_words[d * WORDS + pos[d]];
          pos[d]++;
        end
      end
      OP_MEDIA_DONE: media_done(ok);
      default: ;
    endcase
    res.irq = irq_line;
  endfunction

  function automatic void apply_config(input logic [1:0] idx, input logic [7:0] v);
    case (idx)
      CFG_DRIVE_TYPES:  drive_types = v;
      CFG_INIT_HEADS:   init_heads = v[4:0];
      CFG_INIT_SECTORS: init_sectors = v;
      default: return;
    endcase
    power_all();
  endfunction

  always @(posedge clk) begin
    ata_result_t want;
    if (!rst_n) begin
      drive_types = 8'd1;
      init_heads = 5'd8;
      init_sectors = 8'd17;
      bank[0] = '0; bank[1] = '0;
      sel[0] = 1'b0; sel[1] = 1'b0;
      irq_line = 1'b0;
      power_all();
      pending_results.delete();
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", out_read_data, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_read_data !== want.rd) report("read_data", out_read_data, want.rd);
          if (out_irq !== want.irq) report("irq", out_irq, want.irq);
          if (out_storage_request !== want.req)
            report("storage_request", out_storage_request, want.req);
          if (out_storage_drive !== want.drv)
            report("storage_drive", out_storage_drive, want.drv);
          if (out_storage_lba !== want.lba) report("storage_lba", out_storage_lba, want.lba);
        end
      end
      if (cfg_we) apply_config(cfg_index, cfg_wdata);
      if (start && !busy) begin
        task_file_step(in_operation, in_reg_addr, in_write_data, in_media_ok);
        pending_results.push_back(res);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ----- test/tb.sv -----
// Top of the task-file controller bench. It only makes stimulus and gives
// the verdict; prediction and comparison live in the checker beside the DUT.
module tb;
  import atf_pkg::*;

  // Generous bound: a few thousand requests plus long gaps
  // stay far below this.
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_REQUESTS = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_operation = '0;
  logic [3:0]  in_reg_addr = '0;
  logic [15:0] in_write_data = '0;
  logic        in_media_ok = 1'b0;
  logic        out_valid;
  logic [15:0] out_read_data;
  logic        out_irq;
  logic [1:0]  out_storage_request;
  logic [1:0]  out_storage_drive;
  logic [27:0] out_storage_lba;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int cycles = 0;
  int sent = 0;
  bit steady = 1'b0;

  always #10 clk = ~clk;

  ata_task_file_controller DUT (.*);

  atf_checker u_check (.*);

  // The run is bounded by a cycle count; hitting it means something hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Drives one request and waits for the edge that takes it. Busy is looked
  // at on the falling edge so that the decision never races the DUT. After
  // acceptance the sender may go quiet for a while; start is only lowered
  // when a gap actually follows, so back-to-back requests keep it high.
  task automatic send_request(input logic [2:0] op, input logic [3:0] a,
                              input logic [15:0] wd, input logic ok);
    bit free;
    int r, gap;
    in_operation  <= op;
    in_reg_addr   <= a;
    in_write_data <= wd;
    in_media_ok   <= ok;
    start         <= 1'b1;
    do begin
      @(negedge clk);
      free = !busy;
      @(posedge clk);
    end while (!free);
    sent++;
    if (!steady) begin
      r = $urandom_range(0, 99);
      gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic reg_wr(input logic [3:0] a, input logic [7:0] v);
    send_request(OP_REG_WRITE, a, {8'($urandom), v}, 1'($urandom));
  endtask

  task automatic reg_rd(input logic [3:0] a);
    send_request(OP_REG_READ, a, 16'($urandom), 1'($urandom));
  endtask

  // Waits until every predicted result has come back, then lets the DUT's
  // longest request finish before anything else happens.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  // All three registers are written back to back; each write re-runs the
  // power-on setup of every drive.
  task automatic configure(input logic [7:0] types, input logic [4:0] heads,
                           input logic [7:0] sectors);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DRIVE_TYPES;
    cfg_wdata <= types;
    @(posedge clk);
    cfg_index <= CFG_INIT_HEADS;
    cfg_wdata <= 8'(heads);
    @(posedge clk);
    cfg_index <= CFG_INIT_SECTORS;
    cfg_wdata <= sectors;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Picks channel and drive. Now and then the bank points at no channel so
  // that the no-drive answers get exercised too.
  task automatic select_drive(input logic lba);
    logic [7:0] ch;
    ch = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(2, 127)) : 8'($urandom_range(0, 1));
    reg_wr(A_BANK1, ch);
    reg_wr(A_DRVHEAD, {1'($urandom), lba, 1'($urandom), 1'($urandom), 4'($urandom)});
  endtask

  task automatic place_address();
    reg_wr(A_SECNUM, 8'($urandom));
    reg_wr(A_CYL_LO, 8'($urandom));
    reg_wr(A_CYL_HI, ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(0, 3)));
  endtask

  // A well-formed sector read: command, storage fills the buffer, completion,
  // then the host drains the data port. Most sectors are cut short to keep
  // the run brief; a full sector moves the address and may issue the next.
  task automatic read_sectors();
    logic [7:0] cmd;
    int n, words;
    select_drive(1'($urandom));
    n = $urandom_range(1, 2);
    reg_wr(A_SECCNT, 8'(n));
    place_address();
    case ($urandom_range(0, 2))
      0: cmd = CMD_READ;
      1: cmd = CMD_READ_NR;
      default: cmd = CMD_READ_MULT;
    endcase
    reg_wr(A_COMMAND, cmd);
    for (int s = 0; s < n; s++) begin
      words = ($urandom_range(0, 9) == 0) ? WORDS : $urandom_range(0, 8);
      repeat (words) send_request(OP_MEDIA_FILL, 4'($urandom), 16'($urandom), 1'($urandom));
      send_request(OP_MEDIA_DONE, 4'($urandom), 16'($urandom), $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 2) == 0) reg_rd(A_ALTSTAT);
      words = ($urandom_range(0, 9) == 0) ? WORDS : $urandom_range(0, 8);
      repeat (words) send_request(OP_DATA_READ, 4'($urandom), 16'($urandom), 1'($urandom));
    end
    reg_rd(A_COMMAND);
  endtask

  // A well-formed sector write: the host fills the buffer, storage fetches
  // a few words, then completion steps the address.
  task automatic write_sectors();
    logic [7:0] cmd;
    int n, words;
    select_drive(1'($urandom));
    n = $urandom_range(1, 2);
    reg_wr(A_SECCNT, 8'(n));
    place_address();
    case ($urandom_range(0, 2))
      0: cmd = CMD_WRITE;
      1: cmd = CMD_WRITE_NR;
      default: cmd = CMD_WRITE_MULT;
    endcase
    reg_wr(A_COMMAND, cmd);
    for (int s = 0; s < n; s++) begin
      words = ($urandom_range(0, 9) == 0) ? WORDS : $urandom_range(0, 8);
      repeat (words) send_request(OP_DATA_WRITE, 4'($urandom), 16'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 6))
        send_request(OP_MEDIA_FETCH, 4'($urandom), 16'($urandom), 1'($urandom));
      send_request(OP_MEDIA_DONE, 4'($urandom), 16'($urandom), $urandom_range(0, 9) != 0);
    end
    reg_rd(A_COMMAND);
  endtask

  task automatic set_multiple();
    logic [7:0] cnt;
    case ($urandom_range(0, 6))
      0: cnt = 8'd2;
      1: cnt = 8'd4;
      2: cnt = 8'd8;
      3: cnt = 8'd16;
      4: cnt = 8'd32;
      5: cnt = 8'd3;
      default: cnt = 8'($urandom);
    endcase
    select_drive(1'($urandom));
    reg_wr(A_SECCNT, cnt);
    reg_wr(A_COMMAND, CMD_SET_MULT);
    reg_rd(A_COMMAND);
  endtask

  // The remaining commands, plus unknown codes, each followed by status and
  // error reads; a status read also clears an unmasked interrupt.
  task automatic other_command();
    logic [7:0] cmd;
    case ($urandom_range(0, 5))
      0: cmd = CMD_DIAG;
      1: cmd = CMD_RESET;
      2: cmd = 8'($urandom_range(CMD_RECAL_FIRST, CMD_RECAL_LAST));
      3: cmd = CMD_SET_PARAMS;
      4: cmd = CMD_FLUSH;
      default: cmd = 8'($urandom);
    endcase
    select_drive(1'($urandom));
    reg_wr(A_SECCNT, ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 63)) : 8'($urandom));
    reg_wr(A_COMMAND, cmd);
    reg_rd(A_COMMAND);
    reg_rd(A_FEATURES);
    if ($urandom_range(0, 1) == 0) reg_rd(A_BANK0);
  endtask

  // Soft reset pulse on the selected channel, with interrupt masking chosen
  // at random; a pending transfer on that channel gets cancelled.
  task automatic soft_reset();
    logic [7:0] v;
    v = 8'($urandom);
    reg_wr(A_BANK1, 8'($urandom_range(0, 1)));
    reg_wr(A_DEVCTL, v | 8'(1 << CT_SRST_BIT));
    if ($urandom_range(0, 1) == 0) reg_rd(A_ALTSTAT);
    reg_wr(A_DEVCTL, v & ~8'(1 << CT_SRST_BIT));
    reg_rd(A_FEATURES);
  endtask

  task automatic poke_registers();
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(0, 1) == 0)
        reg_wr(4'($urandom_range(A_BANK0, A_ALTSTAT)), 8'($urandom));
      else
        reg_rd(4'($urandom_range(A_BANK0, A_ALTSTAT)));
    end
  endtask

  task automatic random_traffic(input int budget);
    int stop, r;
    stop = sent + budget;
    while (sent < stop) begin
      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 12)
        send_request(3'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 37) read_sectors();
      else if (r < 57) write_sectors();
      else if (r < 65) set_multiple();
      else if (r < 77) other_command();
      else if (r < 85) soft_reset();
      else poke_registers();
    end
    steady = 1'b0;
  endtask

  initial begin
    logic [7:0] type_set[8];
    type_set = '{8'h55, 8'h55, 8'h96, 8'h00, 8'hff, 8'haa, 8'h59, 8'h00};
    type_set[7] = 8'($urandom);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every drive's buffer gets a full sector written by the host first, so
    // that no later read of the buffer lands on a word never written.
    configure(8'h55, 5'd8, 8'd17);
    for (int ch = 0; ch < 2; ch++) begin
      for (int dv = 0; dv < 2; dv++) begin
        reg_wr(A_BANK1, 8'(ch));
        reg_wr(A_DRVHEAD, 8'(dv << 4));
        reg_wr(A_SECCNT, 8'd1);
        reg_wr(A_COMMAND, CMD_WRITE);
        repeat (WORDS) send_request(OP_DATA_WRITE, '0, 16'($urandom), 1'b0);
        send_request(OP_MEDIA_FETCH, '0, '0, 1'b0);
        send_request(OP_MEDIA_DONE, '0, '0, 1'b1);
      end
    end

    // Directed corners: every address read, unused addresses, the ignored
    // operation code, a bank write with the top bit set, no channel at all,
    // and task registers at their extremes.
    for (int a = 0; a < 16; a++) reg_rd(4'(a));
    reg_wr(4'd12, 8'hff);
    send_request(3'd7, 4'hf, 16'hffff, 1'b1);
    reg_wr(A_BANK1, 8'h81);
    reg_wr(A_BANK1, 8'h02);
    reg_rd(A_SECCNT);
    send_request(OP_DATA_READ, '0, '0, 1'b0);
    reg_wr(A_BANK1, 8'h00);
    reg_wr(A_FEATURES, 8'hff);
    reg_wr(A_CYL_HI, 8'hff);
    reg_rd(A_CYL_HI);
    settle();

    // Several configurations, the extremes among them, each with its own
    // share of random traffic.
    foreach (type_set[i]) begin
      case (i)
        0: configure(type_set[i], 5'd1, 8'd1);
        1: configure(type_set[i], 5'd16, 8'd255);
        default: configure(type_set[i], 5'($urandom_range(1, 16)), 8'($urandom_range(1, 255)));
      endcase
      random_traffic(RANDOM_REQUESTS / 8);
      settle();
    end

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/atf_pkg.sv
rtl/atf_ram.sv
rtl/ata_task_file_controller.sv
rtl/atf_checker.sv
test/atf_checker.sv
test/tb.sv
